// ===== rtl/earliest_free_worker_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_macros
// Assertion macros shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_MACROS_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_MACROS_SVH

// same-cycle implication, checked outside reset
`define EFW_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("efw: same-cycle check failed");

// next-cycle implication, checked outside reset
`define EFW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("efw: next-cycle check failed");

`endif

// ===== rtl/efw_pkg.sv =====
// ----------------------------------------------------------------------------
// efw_pkg
// Shared constants, types and scan state encoding for the scheduler.
// ----------------------------------------------------------------------------
package efw_pkg;

  localparam int MAX_WORKERS_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;

  localparam int DUR_W     = 32;
  localparam int WKR_OUT_W = 4;
  localparam int START_W   = 48;
  localparam int CFG_W     = 5;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_RUN,
    SC_DRAIN
  } scan_state_t;

  // job handed from the front end to the scan engine
  typedef struct packed {
    logic             start;
    logic [DUR_W-1:0] dur;
  } efw_cmd_t;

  // scan engine status back to the front end
  typedef struct packed {
    logic             busy;
    logic [DUR_W-1:0] gap;
  } efw_sts_t;

endpackage

// ===== rtl/efw_if.sv =====
// ----------------------------------------------------------------------------
// efw_if
// Valid/ready channels for job durations and worker assignments.
// ----------------------------------------------------------------------------
interface efw_in_if import efw_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration;

  modport source (output valid, output duration, input ready);
  modport sink   (input valid, input duration, output ready);
endinterface

interface efw_out_if import efw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WKR_OUT_W-1:0] worker;
  logic [START_W-1:0]   start_time;

  modport source (output valid, output worker, output start_time, input ready);
  modport sink   (input valid, input worker, input start_time, output ready);
endinterface

// ===== rtl/earliest_free_worker_scheduler.sv =====
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler
// Assigns each job to the worker that frees up first and reports its start.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready channel carrying one job duration per transaction.
//   out_ch : valid/ready channel returning the chosen worker and the job's
//            absolute start time (wraps modulo 2^TIME_BITS, shown in 48 bits).
//   cfg_wr_en/cfg_wr_data : sets num_workers (0 acts as 1, values above
//            MAX_WORKERS act as MAX_WORKERS); write only while idle.
// Latency: the result is registered at the edge that accepts the job, so it
//   is valid on out_ch the next cycle.
// Throughput: after acceptance the scan engine makes one pass over
//   max(current, previous) worker count entries of the remaining-time memory,
//   one read-modify-write per cycle followed by a drain state for the last
//   write. in_ch.ready is low during the pass.
// Reset: rst_n is synchronous, active low. It clears time, gap, next worker
//   and the per-entry valid bits of the memory; no clearing pass is needed.
// Stall: a result held on out_ch does not block the pass; a new job is
//   taken once the pass is over and the output register is free or drains.
// ----------------------------------------------------------------------------
`include "earliest_free_worker_scheduler_macros.svh"

module earliest_free_worker_scheduler import efw_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  efw_in_if.sink           in_ch,
  efw_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);

  logic [CFG_W-1:0]     num_workers_r;
  logic [CNT_W-1:0]     n_act;
  logic [TIME_BITS-1:0] cur_time_r, cur_time_nxt;
  logic                 out_vld_r;
  logic [WKR_OUT_W-1:0] out_worker_r;
  logic [START_W-1:0]   out_start_r;
  logic                 accept;
  efw_cmd_t             cmd;
  efw_sts_t             sts;
  logic [IDX_W-1:0]     best_worker;

  always_comb begin
    if (num_workers_r == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(num_workers_r) > MAX_WORKERS) begin
      n_act = CNT_W'(MAX_WORKERS);
    end else begin
      n_act = CNT_W'(num_workers_r);
    end
  end

  assign in_ch.ready  = !sts.busy && (!out_vld_r || out_ch.ready);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cur_time_nxt = cur_time_r + TIME_BITS'(sts.gap);

  assign cmd.start = accept;
  assign cmd.dur   = in_ch.duration;

  efw_scan #(
    .MAX_WORKERS (MAX_WORKERS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .n_act       (n_act),
    .sts         (sts),
    .best_worker (best_worker)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_workers_r <= CFG_W'(1);
      cur_time_r    <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        num_workers_r <= cfg_wr_data;
      end
      if (accept) begin
        cur_time_r <= cur_time_nxt;
        out_vld_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_worker_r <= WKR_OUT_W'(best_worker);
      out_start_r  <= START_W'(cur_time_nxt);
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.worker     = out_worker_r;
  assign out_ch.start_time = out_start_r;

  `EFW_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_vld_r)
  `EFW_ASSERT_NEXT(a_accept_starts_pass, clk, rst_n, accept, sts.busy)
  `EFW_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, sts.busy, !in_ch.ready)

endmodule

// ===== rtl/efw_mem.sv =====
// ----------------------------------------------------------------------------
// efw_mem
// Remaining-time store: one write and one registered read port per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module efw_mem import efw_pkg::*; #(
  parameter int DEPTH  = MAX_WORKERS_DEF,
  parameter int IDX_W  = 4,
  parameter int DATA_W = DUR_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_q_r;
  logic              rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

// ===== rtl/efw_scan.sv =====
// ----------------------------------------------------------------------------
// efw_scan
// Per-job pass over the remaining-time store: applies the previous gap,
// inserts the new job, finds the first minimum and keeps it as the next gap.
// ----------------------------------------------------------------------------
`include "earliest_free_worker_scheduler_macros.svh"

module efw_scan import efw_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int IDX_W       = 4,
  parameter int CNT_W       = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  efw_cmd_t         cmd,
  input  logic [CNT_W-1:0] n_act,
  output efw_sts_t         sts,
  output logic [IDX_W-1:0] best_worker
);

  scan_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] m_r;
  logic [CNT_W-1:0] ncur_r;
  logic [CNT_W-1:0] nprev_r, nprev_nxt;
  logic [IDX_W-1:0] w_r;
  logic [DUR_W-1:0] g_r;
  logic [DUR_W-1:0] dur_r;
  logic             p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0] p_idx_r, p_idx_nxt;
  logic [DUR_W-1:0] min_r, min_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;

  logic             go;
  logic             rd_en;
  logic [DUR_W-1:0] rd_val;
  logic [DUR_W-1:0] upd_val;
  logic [CNT_W-1:0] p_ext;
  logic             take;

  efw_mem #(
    .DEPTH  (MAX_WORKERS),
    .IDX_W  (IDX_W),
    .DATA_W (DUR_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (p_vld_r),
    .wr_addr (p_idx_r),
    .wr_data (upd_val),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_val)
  );

  assign go = cmd.start && (state_r == SC_IDLE);

  // sequencer: one read issued per cycle in RUN, then a drain state for the last write
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    nprev_nxt = nprev_r;
    rd_en     = 1'b0;
    p_vld_nxt = 1'b0;
    p_idx_nxt = p_idx_r;
    case (state_r)
      SC_IDLE: begin
        if (go) begin
          cnt_nxt   = '0;
          state_nxt = SC_RUN;
        end
      end
      SC_RUN: begin
        rd_en     = 1'b1;
        p_vld_nxt = 1'b1;
        p_idx_nxt = cnt_r[IDX_W-1:0];
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == m_r - CNT_W'(1)) begin
          state_nxt = SC_DRAIN;
        end
      end
      SC_DRAIN: begin
        nprev_nxt = ncur_r;
        state_nxt = SC_IDLE;
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  // read-modify-write stage; the previous gap only applies to the previous active set
  always_comb begin
    p_ext = CNT_W'(p_idx_r);
    if (p_idx_r == w_r) begin
      upd_val = dur_r;
    end else if (p_ext < nprev_r) begin
      upd_val = rd_val - g_r;
    end else begin
      upd_val = rd_val;
    end
    take     = p_vld_r && (p_ext < ncur_r) && ((p_idx_r == '0) || (upd_val < min_r));
    min_nxt  = take ? upd_val : min_r;
    best_nxt = take ? p_idx_r : best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      nprev_r <= CNT_W'(1);
      p_vld_r <= 1'b0;
      min_r   <= '0;
      best_r  <= '0;
    end else begin
      state_r <= state_nxt;
      nprev_r <= nprev_nxt;
      p_vld_r <= p_vld_nxt;
      min_r   <= min_nxt;
      best_r  <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    p_idx_r <= p_idx_nxt;
    if (go) begin
      w_r    <= best_r;
      g_r    <= min_r;
      dur_r  <= cmd.dur;
      ncur_r <= n_act;
      m_r    <= (n_act > nprev_r) ? n_act : nprev_r;
    end
  end

  assign sts.busy    = (state_r != SC_IDLE);
  assign sts.gap     = min_r;
  assign best_worker = best_r;

  `EFW_ASSERT_IMPL(a_start_when_idle, clk, rst_n, cmd.start, state_r == SC_IDLE)
  `EFW_ASSERT_IMPL(a_wr_in_pass, clk, rst_n, p_vld_r, p_ext < m_r)
  `EFW_ASSERT_IMPL(a_job_slot_active, clk, rst_n, state_r == SC_RUN, CNT_W'(w_r) < nprev_r)
  `EFW_ASSERT_NEXT(a_best_active, clk, rst_n, state_r == SC_DRAIN, CNT_W'(best_r) < ncur_r)

endmodule

// ===== sim/earliest_free_worker_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_test
// Drives job durations into the scheduler under several worker counts and
// checks every worker/start-time result against a cycle-free model of the
// earliest-free assignment, with random gaps on both channels and one long
// output stall that backs the block up.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_test import efw_pkg::*;;

  localparam int WORKERS     = MAX_WORKERS_DEF;
  localparam int RUN_LIMIT   = 1_000_000;
  localparam int PASS_SETTLE = 24;   // one scan pass plus margin
  localparam int LONG_HOLD   = 400;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_JOBS  = 113;

  typedef struct packed {
    logic [WKR_OUT_W-1:0] worker;
    logic [START_W-1:0]   start_time;
  } assignment_t;

  class sched_scoreboard;
    logic [DUR_W-1:0]   busy_left [WORKERS];
    logic [START_W-1:0] now_ticks;
    logic [DUR_W-1:0]   gap_to_free;
    int unsigned        first_free;
    logic [CFG_W-1:0]   worker_count;
    assignment_t        due_assignments [$];
    int unsigned        mismatches;

    function new();
      foreach (busy_left[i]) busy_left[i] = '0;
      now_ticks    = '0;
      gap_to_free  = '0;
      first_free   = 0;
      worker_count = 1;
      mismatches   = 0;
    endfunction

    function void set_worker_count(logic [CFG_W-1:0] v);
      worker_count = v;
    endfunction

    function int pending();
      return due_assignments.size();
    endfunction

    // advance to the next free instant, hand the job to the chosen worker,
    // then rescan the active workers for the first minimum
    function void note_job(logic [DUR_W-1:0] dur);
      int unsigned      n;
      int unsigned      best;
      logic [DUR_W-1:0] low;
      assignment_t      slot;
      if (worker_count == 0) n = 1;
      else if (worker_count > WORKERS) n = WORKERS;
      else n = worker_count;
      now_ticks = now_ticks + START_W'(gap_to_free);
      if (first_free >= WORKERS) first_free = 0;
      slot.worker     = WKR_OUT_W'(first_free);
      slot.start_time = now_ticks;
      due_assignments.push_back(slot);
      busy_left[first_free] = dur;
      best = 0;
      low  = busy_left[0];
      for (int i = 1; i < n; i++) begin
        if (busy_left[i] < low) begin
          low  = busy_left[i];
          best = i;
        end
      end
      for (int i = 0; i < n; i++) busy_left[i] -= low;
      gap_to_free = low;
      first_free  = best;
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s at %0t: expected 0x%0h, got 0x%0h", what, $realtime, want, got);
    endfunction

    function void check_result(logic [WKR_OUT_W-1:0] worker, logic [START_W-1:0] start_time);
      assignment_t want;
      if (due_assignments.size() == 0) begin
        flag("result with nothing pending", '0, {worker, start_time});
        return;
      end
      want = due_assignments.pop_front();
      if (worker !== want.worker) flag("worker", want.worker, worker);
      if (start_time !== want.start_time) flag("start_time", want.start_time, start_time);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  bit               send_quiet;
  bit               recv_quiet;
  bit               hold_output;
  sched_scoreboard  sb;

  efw_in_if  in_ch ();
  efw_out_if out_ch ();

  earliest_free_worker_scheduler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DUR_W-1:0] draw_duration();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      3, 4, 5: return $urandom_range(0, 63);   // small values give many ties
      default: return $urandom();
    endcase
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_job(input logic [DUR_W-1:0] dur);
    int unsigned wait_cycles;
    wait_cycles = send_quiet ? 0 : $urandom_range(0, 17);
    if (wait_cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.duration <= dur;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_job(dur);
  endtask

  // only while idle: drain results, let the scan pass finish, then write
  task automatic load_count(input logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PASS_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_worker_count(v);
  endtask

  initial begin
    int unsigned      wait_cycles;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      wait_cycles = recv_quiet ? 0 : $urandom_range(0, 17);
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
      end else if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      sb.check_result(out_ch.worker, out_ch.start_time);
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] fixed_counts [6];
    logic [CFG_W-1:0] cnt;
    fixed_counts = '{5'd16, 5'd16, 5'd2, 5'd31, 5'd0, 5'd1};
    sb             = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.duration = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    send_quiet     = 1'b0;
    recv_quiet     = 1'b0;
    hold_output    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single worker: extremes and bit patterns
    load_count(5'd1);
    send_job(32'h0000_0000);
    send_job(32'hFFFF_FFFF);
    send_job(32'h0000_0001);
    send_job(32'hAAAA_AAAA);
    send_job(32'h5555_5555);
    send_job(32'h8000_0000);
    send_job(32'h7FFF_FFFF);
    // zero count behaves as one worker
    load_count(5'd0);
    send_job(32'd10);
    send_job(32'd3);
    send_job(32'd0);
    // oversized count clamps to all workers; equal durations tie low
    load_count(5'd31);
    send_job(32'd5);
    send_job(32'd5);
    send_job(32'd5);
    send_job(32'd5);
    send_job(32'd0);
    send_job(32'hFFFF_FFFF);
    send_job(32'd2);
    send_job(32'd2);
    // shrink: pending next worker may sit beyond the new count
    load_count(5'd3);
    send_job(32'd1);
    send_job(32'd1);
    send_job(32'd4);
    // grow again: reactivated workers keep stale busy times
    load_count(5'd17);
    send_job(32'd0);
    send_job(32'hFFFF_FFFE);
    send_job(32'd3);

    for (int p = 0; p < RAND_PHASES; p++) begin
      cnt        = (p < 6) ? fixed_counts[p] : CFG_W'($urandom_range(0, 31));
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      load_count(cnt);
      if (p == 1) begin
        // flood the input while the output is held off
        send_quiet  = 1'b1;
        hold_output = 1'b1;
      end
      repeat (PHASE_JOBS) send_job(draw_duration());
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PASS_SETTLE) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
